### rtl/dqat_pkg.sv
// types, constants and the quadrature decode table of the axis tracker
package dqat_pkg;

  localparam int unsigned SampleWidth    = 6;
  localparam int unsigned XMaxWidth      = 31;
  localparam int unsigned CountWidth     = 32;
  localparam int unsigned OutPosWidth    = 32;
  localparam int unsigned DefPositionWidth = 32;

  typedef enum logic [1:0] {
    STEP_FWD,
    STEP_BACK,
    STEP_ILLEGAL
  } step_e;

  // transition codes, {old pair, new pair}
  localparam logic [3:0] TrFwd0  = 4'b0001;
  localparam logic [3:0] TrFwd1  = 4'b0111;
  localparam logic [3:0] TrFwd2  = 4'b1110;
  localparam logic [3:0] TrFwd3  = 4'b1000;
  localparam logic [3:0] TrBack0 = 4'b0100;
  localparam logic [3:0] TrBack1 = 4'b1101;
  localparam logic [3:0] TrBack2 = 4'b1011;
  localparam logic [3:0] TrBack3 = 4'b0010;

  typedef struct packed {
    logic [OutPosWidth-1:0] x_position;
    logic [OutPosWidth-1:0] y_position;
    logic [CountWidth-1:0]  x_error_count;
    logic [CountWidth-1:0]  y_error_count;
    logic                   paper_flag;
    logic                   head_at_max;
    logic                   x_motor_stop;
  } result_t;

  function automatic step_e decode_step(input logic [1:0] old_pair,
                                        input logic [1:0] new_pair);
    logic [3:0] code;
    step_e      step;
    code = {old_pair, new_pair};
    if (code == TrFwd0 || code == TrFwd1 || code == TrFwd2 || code == TrFwd3) begin
      step = STEP_FWD;
    end else if (code == TrBack0 || code == TrBack1 || code == TrBack2 ||
                 code == TrBack3) begin
      step = STEP_BACK;
    end else begin
      step = STEP_ILLEGAL;
    end
    return step;
  endfunction

endpackage

### rtl/dual_quadrature_axis_tracker_top.sv
// dual quadrature axis tracker: x/y x4 decode, error counts, paper and head-limit flags
// throughput: one item per cycle while the skid register is empty; decode and the
// position adders sit between the sample handshake and the output register, a skid register absorbs one stall
// reset: positions, error counts, flags, previous sample and x_max clear to zero,
// output and skid registers empty
module dual_quadrature_axis_tracker_top import dqat_pkg::*; #(
  parameter int unsigned POSITION_WIDTH = DefPositionWidth
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [SampleWidth-1:0] sensor_sample_i,
  input  logic                   cfg_we_i,
  input  logic [XMaxWidth-1:0]   cfg_wdata_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [OutPosWidth-1:0] x_position_o,
  output logic [OutPosWidth-1:0] y_position_o,
  output logic [CountWidth-1:0]  x_error_count_o,
  output logic [CountWidth-1:0]  y_error_count_o,
  output logic                   paper_flag_o,
  output logic                   head_at_max_o,
  output logic                   x_motor_stop_o
);

  logic [XMaxWidth-1:0]      x_max_q;
  logic [SampleWidth-1:0]    prev_q, prev_d;
  logic [POSITION_WIDTH-1:0] x_count_q, x_count_d;
  logic [POSITION_WIDTH-1:0] y_count_q, y_count_d;
  logic [CountWidth-1:0]     x_err_q, x_err_d;
  logic [CountWidth-1:0]     y_err_q, y_err_d;
  logic                      paper_q, paper_d;
  logic                      head_q, head_d;
  logic                      stop;

  result_t res_new;
  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;

  logic in_acc;
  logic out_take;

  logic [SampleWidth-1:0] changes;
  step_e                  x_step, y_step;
  logic [63:0]            x_max_wide;
  logic signed [63:0]     x_ext, y_ext;

  assign in_acc   = in_valid_i & ~in_stall_o;
  assign out_take = out_valid_q & ~out_stall_i;
  assign changes  = sensor_sample_i ^ prev_q;
  assign x_step   = decode_step(prev_q[1:0], sensor_sample_i[1:0]);
  assign y_step   = decode_step(prev_q[3:2], sensor_sample_i[3:2]);
  assign x_max_wide = 64'(x_max_q);

  always_comb begin
    prev_d    = sensor_sample_i;
    x_count_d = x_count_q;
    y_count_d = y_count_q;
    x_err_d   = x_err_q;
    y_err_d   = y_err_q;
    paper_d   = paper_q;
    head_d    = head_q;
    stop      = 1'b0;

    if (changes[1:0] != 2'b00) begin
      unique case (x_step)
        STEP_FWD:  x_count_d = x_count_q + POSITION_WIDTH'(1);
        STEP_BACK: x_count_d = x_count_q - POSITION_WIDTH'(1);
        default:   x_err_d   = x_err_q + CountWidth'(1);
      endcase
    end
    if (changes[3:2] != 2'b00) begin
      unique case (y_step)
        STEP_FWD:  y_count_d = y_count_q + POSITION_WIDTH'(1);
        STEP_BACK: y_count_d = y_count_q - POSITION_WIDTH'(1);
        default:   y_err_d   = y_err_q + CountWidth'(1);
      endcase
    end
    if (changes[4]) begin
      paper_d = sensor_sample_i[4];
    end
    if (changes[5]) begin
      head_d = ~sensor_sample_i[5];
      // falling limit line overrides any x step of this item
      if (!sensor_sample_i[5]) begin
        x_count_d = x_max_wide[POSITION_WIDTH-1:0];
        stop      = 1'b1;
      end
    end
  end

  // sign extend from the position width, then take the low 32 bits
  assign x_ext = 64'(signed'(x_count_d));
  assign y_ext = 64'(signed'(y_count_d));

  always_comb begin
    res_new.x_position    = x_ext[OutPosWidth-1:0];
    res_new.y_position    = y_ext[OutPosWidth-1:0];
    res_new.x_error_count = x_err_d;
    res_new.y_error_count = y_err_d;
    res_new.paper_flag    = paper_d;
    res_new.head_at_max   = head_d;
    res_new.x_motor_stop  = stop;
  end

  // output register with one skid entry
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res_new;
        out_valid_d = in_acc;
      end
    end else if (in_acc) begin
      skid_d       = res_new;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_max_q      <= '0;
      prev_q       <= '0;
      x_count_q    <= '0;
      y_count_q    <= '0;
      x_err_q      <= '0;
      y_err_q      <= '0;
      paper_q      <= 1'b0;
      head_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        x_max_q <= cfg_wdata_i;
      end
      if (in_acc) begin
        prev_q    <= prev_d;
        x_count_q <= x_count_d;
        y_count_q <= y_count_d;
        x_err_q   <= x_err_d;
        y_err_q   <= y_err_d;
        paper_q   <= paper_d;
        head_q    <= head_d;
      end
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign in_stall_o      = skid_valid_q;
  assign out_valid_o     = out_valid_q;
  assign x_position_o    = out_q.x_position;
  assign y_position_o    = out_q.y_position;
  assign x_error_count_o = out_q.x_error_count;
  assign y_error_count_o = out_q.y_error_count;
  assign paper_flag_o    = out_q.paper_flag;
  assign head_at_max_o   = out_q.head_at_max;
  assign x_motor_stop_o  = out_q.x_motor_stop;

endmodule

### tb/tb.sv
// self-checking testbench of the dual quadrature axis tracker with a queue-based scoreboard
`timescale 1ns / 1ps

module tb import dqat_pkg::*; ();

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned HoldAfter  = 250;
  localparam int unsigned PhaseItems = 106;

  class tracker_scoreboard;
    logic [SampleWidth-1:0] last_sample;
    logic [OutPosWidth-1:0] x_pos;
    logic [OutPosWidth-1:0] y_pos;
    logic [CountWidth-1:0]  x_err;
    logic [CountWidth-1:0]  y_err;
    logic                   paper;
    logic                   head;
    logic [XMaxWidth-1:0]   x_limit;
    result_t                predicted_readings[$];
    int unsigned            fail_count;
    int unsigned            checked_count;

    function new();
      last_sample   = '0;
      x_pos         = '0;
      y_pos         = '0;
      x_err         = '0;
      y_err         = '0;
      paper         = 1'b0;
      head          = 1'b0;
      x_limit       = '0;
      fail_count    = 0;
      checked_count = 0;
    endfunction

    function void set_limit(logic [XMaxWidth-1:0] v);
      x_limit = v;
    endfunction

    function step_e classify(logic [1:0] old_pair, logic [1:0] new_pair);
      step_e step;
      case ({old_pair, new_pair})
        TrFwd0, TrFwd1, TrFwd2, TrFwd3:     step = STEP_FWD;
        TrBack0, TrBack1, TrBack2, TrBack3: step = STEP_BACK;
        default:                            step = STEP_ILLEGAL;
      endcase
      return step;
    endfunction

    function void move_axis(logic [1:0] old_pair, logic [1:0] new_pair,
                            inout logic [OutPosWidth-1:0] pos,
                            inout logic [CountWidth-1:0] err);
      case (classify(old_pair, new_pair))
        STEP_FWD:  pos = pos + OutPosWidth'(1);
        STEP_BACK: pos = pos - OutPosWidth'(1);
        default:   err = err + CountWidth'(1);
      endcase
    endfunction

    function void note_sample(logic [SampleWidth-1:0] s);
      logic [SampleWidth-1:0] diff;
      result_t                r;
      diff = s ^ last_sample;
      r.x_motor_stop = 1'b0;
      if (|diff[1:0]) move_axis(last_sample[1:0], s[1:0], x_pos, x_err);
      if (|diff[3:2]) move_axis(last_sample[3:2], s[3:2], y_pos, y_err);
      if (diff[4]) paper = s[4];
      if (diff[5]) begin
        head = ~s[5];
        // limit wins over a step on the same item
        if (head) begin
          x_pos = {1'b0, x_limit};
          r.x_motor_stop = 1'b1;
        end
      end
      last_sample     = s;
      r.x_position    = x_pos;
      r.y_position    = y_pos;
      r.x_error_count = x_err;
      r.y_error_count = y_err;
      r.paper_flag    = paper;
      r.head_at_max   = head;
      predicted_readings.push_back(r);
    endfunction

    function void check_readout(result_t got);
      result_t want;
      checked_count++;
      if (predicted_readings.size() == 0) begin
        $error("result item with no expectation waiting");
        fail_count++;
        return;
      end
      want = predicted_readings.pop_front();
      if (got.x_position !== want.x_position) begin
        $error("x_position: expected %0d actual %0d",
               $signed(want.x_position), $signed(got.x_position));
        fail_count++;
      end
      if (got.y_position !== want.y_position) begin
        $error("y_position: expected %0d actual %0d",
               $signed(want.y_position), $signed(got.y_position));
        fail_count++;
      end
      if (got.x_error_count !== want.x_error_count) begin
        $error("x_error_count: expected %0d actual %0d", want.x_error_count, got.x_error_count);
        fail_count++;
      end
      if (got.y_error_count !== want.y_error_count) begin
        $error("y_error_count: expected %0d actual %0d", want.y_error_count, got.y_error_count);
        fail_count++;
      end
      if (got.paper_flag !== want.paper_flag) begin
        $error("paper_flag: expected %0b actual %0b", want.paper_flag, got.paper_flag);
        fail_count++;
      end
      if (got.head_at_max !== want.head_at_max) begin
        $error("head_at_max: expected %0b actual %0b", want.head_at_max, got.head_at_max);
        fail_count++;
      end
      if (got.x_motor_stop !== want.x_motor_stop) begin
        $error("x_motor_stop: expected %0b actual %0b", want.x_motor_stop, got.x_motor_stop);
        fail_count++;
      end
    endfunction

    function bit is_empty();
      return predicted_readings.size() == 0;
    endfunction

    function void flush_leftover();
      if (predicted_readings.size() != 0) begin
        $error("%0d expected result items never arrived", predicted_readings.size());
        fail_count += predicted_readings.size();
        predicted_readings.delete();
      end
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_stall_o;
  logic [SampleWidth-1:0] sensor_sample_i;
  logic                   cfg_we_i;
  logic [XMaxWidth-1:0]   cfg_wdata_i;
  logic                   out_valid_o;
  logic                   out_stall_i;
  logic [OutPosWidth-1:0] x_position_o;
  logic [OutPosWidth-1:0] y_position_o;
  logic [CountWidth-1:0]  x_error_count_o;
  logic [CountWidth-1:0]  y_error_count_o;
  logic                   paper_flag_o;
  logic                   head_at_max_o;
  logic                   x_motor_stop_o;

  tracker_scoreboard sb = new();

  bit                     no_idle;
  bit                     hold_done;
  int unsigned            hold_left;
  int unsigned            cycle_count;
  logic [SampleWidth-1:0] walk_sample;

  dual_quadrature_axis_tracker_top u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sensor_sample_i(sensor_sample_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .x_position_o   (x_position_o),
    .y_position_o   (y_position_o),
    .x_error_count_o(x_error_count_o),
    .y_error_count_o(y_error_count_o),
    .paper_flag_o   (paper_flag_o),
    .head_at_max_o  (head_at_max_o),
    .x_motor_stop_o (x_motor_stop_o)
  );

  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // accepted sample items feed the predictor
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) sb.note_sample(sensor_sample_i);
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.x_position    = x_position_o;
      got.y_position    = y_position_o;
      got.x_error_count = x_error_count_o;
      got.y_error_count = y_error_count_o;
      got.paper_flag    = paper_flag_o;
      got.head_at_max   = head_at_max_o;
      got.x_motor_stop  = x_motor_stop_o;
      sb.check_readout(got);
    end
  end

  // receiver: random stalls plus one long hold-off that fills the block
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left   <= hold_left - 1;
    end else if (!hold_done && sb.checked_count >= HoldAfter) begin
      hold_done   <= 1'b1;
      hold_left   <= HoldCycles;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= no_idle ? 1'b0 : ($urandom_range(99) < 18);
    end
  end

  task automatic send_item(input logic [SampleWidth-1:0] s);
    while (!no_idle && $urandom_range(99) < 18) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    sensor_sample_i <= s;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (!sb.is_empty()) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_x_limit(input logic [XMaxWidth-1:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_limit(v);
  endtask

  function automatic logic [1:0] gray_move(logic [1:0] p, int unsigned dir);
    logic [1:0] n;
    n = p;
    if (dir == 1) begin
      case (p)
        2'b00: n = 2'b01;
        2'b01: n = 2'b11;
        2'b11: n = 2'b10;
        default: n = 2'b00;
      endcase
    end else if (dir == 2) begin
      case (p)
        2'b00: n = 2'b10;
        2'b10: n = 2'b11;
        2'b11: n = 2'b01;
        default: n = 2'b00;
      endcase
    end
    return n;
  endfunction

  initial begin
    logic [SampleWidth-1:0] directed_samples[$];
    logic [XMaxWidth-1:0]   limits[$];
    logic [XMaxWidth-1:0]   rnd_limit;
    logic [SampleWidth-1:0] s;
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    sensor_sample_i = '0;
    cfg_we_i        = 1'b0;
    cfg_wdata_i     = '0;
    out_stall_i     = 1'b0;
    no_idle         = 1'b0;
    hold_done       = 1'b0;
    hold_left       = 0;
    cycle_count     = 0;
    walk_sample     = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // all eight legal transitions and some illegal jumps on both axes, then paper and head-limit cases
    directed_samples = {6'h00,
                        6'h09, 6'h0F, 6'h06, 6'h00,
                        6'h06, 6'h0F, 6'h09, 6'h00,
                        6'h0F, 6'h00, 6'h09, 6'h06, 6'h00,
                        6'h10, 6'h30, 6'h11, 6'h13, 6'h12, 6'h33, 6'h00};
    write_x_limit({XMaxWidth{1'b1}});
    foreach (directed_samples[i]) send_item(directed_samples[i]);
    wait_drained();

    rnd_limit = XMaxWidth'($urandom());
    limits.push_back('0);
    limits.push_back(rnd_limit);
    limits.push_back({XMaxWidth{1'b1}});
    limits.push_back(31'd1);
    rnd_limit = XMaxWidth'($urandom());
    limits.push_back(rnd_limit);
    walk_sample = 6'h00;
    foreach (limits[p]) begin
      write_x_limit(limits[p]);
      no_idle = (p == 2);
      for (int unsigned k = 0; k < PhaseItems; k++) begin
        if ($urandom_range(99) < 85) begin
          s      = walk_sample;
          s[1:0] = gray_move(walk_sample[1:0], $urandom_range(2));
          s[3:2] = gray_move(walk_sample[3:2], $urandom_range(2));
          if ($urandom_range(99) < 10) s[4] = ~s[4];
          if ($urandom_range(99) < 10) s[5] = ~s[5];
        end else begin
          s = SampleWidth'($urandom());
        end
        walk_sample = s;
        send_item(s);
      end
      no_idle = 1'b0;
      wait_drained();
    end

    sb.flush_leftover();
    if (sb.fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
